FILE: rtl/core/frot_pkg.sv
`default_nettype none
package frot_pkg;

	localparam int MAX_DIM      = 256;
	localparam int DIM_BITS     = $clog2(MAX_DIM) + 1;
	localparam int POS_BITS     = $clog2(MAX_DIM);
	localparam int ADDR_BITS    = 2 * POS_BITS;
	localparam int PIXEL_BITS   = 32;
	localparam int QUEUE_DEPTH  = 2;
	localparam int CFG_IDX_BITS = 2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	localparam logic [1:0] MODE_ROT90  = 2'd0;
	localparam logic [1:0] MODE_ROT180 = 2'd1;
	localparam logic [1:0] MODE_ROT270 = 2'd2;

	localparam logic [CFG_IDX_BITS-1:0] REG_ROTATION_MODE = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_WIDTH  = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_HEIGHT = CFG_IDX_BITS'(2);

	typedef struct packed {
		logic [1:0]          rotation_mode;
		logic [DIM_BITS-1:0] source_width;
		logic [DIM_BITS-1:0] source_height;
	} cfg_t;

	typedef struct packed {
		logic                  op;
		logic [ADDR_BITS-1:0]  addr;
		logic [PIXEL_BITS-1:0] pixel;
		logic                  last;
	} job_t;

endpackage
`default_nettype wire

FILE: rtl/core/frot_front.sv
`default_nettype none
module frot_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  frot_pkg::cfg_t                  cfg,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            operation,
	input  logic [frot_pkg::PIXEL_BITS-1:0] pixel_in,
	input  logic                            queue_full,
	output logic                            push,
	output frot_pkg::job_t                  push_job
);
	import frot_pkg::*;

	localparam int PROD_BITS = 2 * DIM_BITS;
	localparam int MUL_BITS  = POS_BITS + DIM_BITS;

	function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
		logic [DIM_BITS-1:0] res;
		res = v;
		if (v == '0)
			res = DIM_BITS'(1);
		else if (v > DIM_BITS'(MAX_DIM))
			res = DIM_BITS'(MAX_DIM);
		return res;
	endfunction

	logic [ADDR_BITS-1:0] load_pos_q;
	logic [POS_BITS-1:0]  out_row_q;
	logic [POS_BITS-1:0]  out_col_q;

	logic [DIM_BITS-1:0]  w, h, ow, oh;
	logic [PROD_BITS-1:0] total;
	logic [ADDR_BITS-1:0] lp_eff, lp_next;
	logic [PROD_BITS-1:0] lp_inc;
	logic                 stale;
	logic [POS_BITS-1:0]  r, c, sr, sc, row_next, col_next;
	logic [DIM_BITS-1:0]  sr_full, sc_full, c_inc, r_inc;
	logic [MUL_BITS-1:0]  addr_sum;
	logic                 last;

	assign w     = clamp_dim(cfg.source_width);
	assign h     = clamp_dim(cfg.source_height);
	assign total = PROD_BITS'(w) * PROD_BITS'(h);

	// load position, restarted when a new frame size left it outside
	always_comb begin
		lp_eff  = (PROD_BITS'(load_pos_q) >= total) ? '0 : load_pos_q;
		lp_inc  = PROD_BITS'(lp_eff) + PROD_BITS'(1);
		lp_next = (lp_inc >= total) ? '0 : lp_inc[ADDR_BITS-1:0];
	end

	always_comb begin
		ow    = (cfg.rotation_mode == MODE_ROT180) ? w : h;
		oh    = (cfg.rotation_mode == MODE_ROT180) ? h : w;
		stale = (DIM_BITS'(out_row_q) >= oh) || (DIM_BITS'(out_col_q) >= ow);
		r     = stale ? '0 : out_row_q;
		c     = stale ? '0 : out_col_q;
		unique case (cfg.rotation_mode)
			MODE_ROT90: begin
				sr_full = h - DIM_BITS'(1) - DIM_BITS'(c);
				sc_full = DIM_BITS'(r);
			end
			MODE_ROT180: begin
				sr_full = h - DIM_BITS'(1) - DIM_BITS'(r);
				sc_full = w - DIM_BITS'(1) - DIM_BITS'(c);
			end
			// three quarter turns, the unused code included
			default: begin
				sr_full = DIM_BITS'(c);
				sc_full = w - DIM_BITS'(1) - DIM_BITS'(r);
			end
		endcase
		sr       = sr_full[POS_BITS-1:0];
		sc       = sc_full[POS_BITS-1:0];
		addr_sum = MUL_BITS'(sr) * MUL_BITS'(w) + MUL_BITS'(sc);
		last     = (DIM_BITS'(r) == oh - DIM_BITS'(1)) && (DIM_BITS'(c) == ow - DIM_BITS'(1));
		c_inc    = DIM_BITS'(c) + DIM_BITS'(1);
		r_inc    = DIM_BITS'(r) + DIM_BITS'(1);
		if (c_inc < ow) begin
			col_next = c_inc[POS_BITS-1:0];
			row_next = r;
		end else begin
			col_next = '0;
			row_next = (r_inc < oh) ? r_inc[POS_BITS-1:0] : '0;
		end
	end

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		push_job.op    = operation;
		push_job.addr  = (operation == OP_LOAD) ? lp_eff : addr_sum[ADDR_BITS-1:0];
		push_job.pixel = pixel_in;
		push_job.last  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			out_row_q  <= '0;
			out_col_q  <= '0;
		end else if (push) begin
			if (operation == OP_LOAD) begin
				load_pos_q <= lp_next;
			end else begin
				out_row_q <= row_next;
				out_col_q <= col_next;
			end
		end
	end

	// the last pixel of a frame sends fetching back to the origin
	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(push && operation == OP_FETCH && last) |=> (out_row_q == '0 && out_col_q == '0))
		else $error("fetch position did not wrap after last pixel");

	a_load_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(push && operation == OP_LOAD) |-> (PROD_BITS'(push_job.addr) < total))
		else $error("load address outside frame");

	// no write while the queue is full
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		queue_full |-> !push)
		else $error("push into full queue");

endmodule
`default_nettype wire

FILE: rtl/core/frot_queue.sv
`default_nettype none
module frot_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  frot_pkg::job_t push_job,
	output logic           full,
	output logic           head_valid,
	output frot_pkg::job_t head_job,
	input  logic           pop
);
	import frot_pkg::*;

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	job_t                entries_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
		return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
	endfunction

	assign full       = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CNT_BITS'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_BITS'(1);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: rtl/core/frot_back.sv
`default_nettype none
module frot_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  frot_pkg::job_t                  head_job,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [frot_pkg::PIXEL_BITS-1:0] pixel_out,
	output logic                            frame_end
);
	import frot_pkg::*;

	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

	logic [PIXEL_BITS-1:0] frame_store [STORE_DEPTH];
	logic [PIXEL_BITS-1:0] rd_data_q;
	logic                  last_q;
	logic                  out_valid_q;
	logic                  out_free, load_pop, fetch_pop;

	assign out_free  = !out_valid_q || !out_stall;
	assign load_pop  = head_valid && (head_job.op == OP_LOAD);
	// a fetch waits for room in the output register
	assign fetch_pop = head_valid && (head_job.op == OP_FETCH) && out_free;
	assign pop       = load_pop || fetch_pop;

	always_ff @(posedge clk) begin
		if (load_pop)
			frame_store[head_job.addr] <= head_job.pixel;
	end

	always_ff @(posedge clk) begin
		if (fetch_pop) begin
			rd_data_q <= frame_store[head_job.addr];
			last_q    <= head_job.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fetch_pop)
			out_valid_q <= 1'b1;
		else if (out_free)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign pixel_out = rd_data_q;
	assign frame_end = last_q;

	a_fetch_shows: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_pop |=> out_valid_q)
		else $error("fetched item not presented");

	// a load slipping past a held result must not disturb it
	a_load_keeps_result: assert property (@(posedge clk) disable iff (!arst_n)
		(load_pop && out_valid_q && out_stall) |=> ($stable(rd_data_q) && out_valid_q))
		else $error("held result changed by a load");

endmodule
`default_nettype wire

FILE: rtl/core/frame_rotator_quarter_turns_core.sv
`default_nettype none
// Frame rotator by quarter turns. Load items (operation 0) write source pixels in raster
// order into a 256x256 single-port frame store; fetch items (operation 1) return the
// rotated frame in output raster order, with frame_end on its last pixel. The front part
// computes the store address (one multiply, row times width) and the back part makes one
// frame store access per cycle, so one item per cycle is sustained unless a stalled output
// holds back a fetch; a fetch result passes through the two-entry queue and the registered
// store read before it is presented. Store entries read before being loaded return
// undefined data; there is no clearing pass after reset.
// Configuration is always ready and must only be written while the block is idle.
module frame_rotator_quarter_turns_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic [frot_pkg::PIXEL_BITS-1:0]   pixel_in,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [frot_pkg::PIXEL_BITS-1:0]   pixel_out,
	output logic                              frame_end,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [frot_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [frot_pkg::DIM_BITS-1:0]     cfg_data
);
	import frot_pkg::*;

	cfg_t cfg_q;
	logic push, queue_full, head_valid, pop;
	job_t push_job, head_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotation_mode <= MODE_ROT90;
			cfg_q.source_width  <= DIM_BITS'(MAX_DIM);
			cfg_q.source_height <= DIM_BITS'(MAX_DIM);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROTATION_MODE: cfg_q.rotation_mode <= cfg_data[1:0];
				REG_SOURCE_WIDTH:  cfg_q.source_width  <= cfg_data;
				REG_SOURCE_HEIGHT: cfg_q.source_height <= cfg_data;
				default: ;
			endcase
		end
	end

	frot_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.pixel_in   (pixel_in),
		.queue_full (queue_full),
		.push       (push),
		.push_job   (push_job)
	);

	frot_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop)
	);

	frot_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_out  (pixel_out),
		.frame_end  (frame_end)
	);

endmodule
`default_nettype wire

FILE: tb/tb_frame_rotator_quarter_turns_core.sv
`timescale 1ns / 100ps
module tb_frame_rotator_quarter_turns_core;
	import frot_pkg::*;

	// the two-bit mode field has a fourth code, decoded as 270 degrees
	localparam logic [1:0] MODE_ROT270_ALT = 2'd3;
	localparam int STORE_DEPTH    = MAX_DIM * MAX_DIM;
	localparam int RANDOM_ITEMS   = 650;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel;
		logic                  frame_end;
	} rotated_pixel_t;

	class rotation_scoreboard;
		logic [PIXEL_BITS-1:0] frame_pixels [STORE_DEPTH];
		bit                    loaded [STORE_DEPTH];
		int                    load_pos;
		int                    out_row;
		int                    out_col;
		logic [1:0]            mode;
		logic [DIM_BITS-1:0]   width;
		logic [DIM_BITS-1:0]   height;
		rotated_pixel_t        pending_pixels [$];
		int                    errors;

		function new();
			mode = MODE_ROT90;
			width = DIM_BITS'(MAX_DIM);
			height = DIM_BITS'(MAX_DIM);
			load_pos = 0;
			out_row = 0;
			out_col = 0;
			errors = 0;
		endfunction

		function int clamp_dim(logic [DIM_BITS-1:0] v);
			if (v == 0)
				return 1;
			if (v > MAX_DIM)
				return MAX_DIM;
			return int'(v);
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] index, logic [DIM_BITS-1:0] data);
			case (index)
				REG_ROTATION_MODE: mode = data[1:0];
				REG_SOURCE_WIDTH:  width = data;
				REG_SOURCE_HEIGHT: height = data;
				default: ;
			endcase
		endfunction

		// odd quarter turns swap the source axes; a half turn keeps them
		function void out_size(output int ow, output int oh);
			int w;
			int h;
			w = clamp_dim(width);
			h = clamp_dim(height);
			if (mode == MODE_ROT180) begin
				ow = w;
				oh = h;
			end else begin
				ow = h;
				oh = w;
			end
		endfunction

		// store index of the next output pixel; a position outside the frame restarts it
		function int next_source(output int r, output int c);
			int w;
			int h;
			int ow;
			int oh;
			int sr;
			int sc;
			w = clamp_dim(width);
			h = clamp_dim(height);
			out_size(ow, oh);
			r = out_row;
			c = out_col;
			if (r >= oh || c >= ow) begin
				r = 0;
				c = 0;
			end
			case (mode)
				MODE_ROT90: begin
					sr = h - 1 - c;
					sc = r;
				end
				MODE_ROT180: begin
					sr = h - 1 - r;
					sc = w - 1 - c;
				end
				default: begin
					sr = c;
					sc = w - 1 - r;
				end
			endcase
			return sr * w + sc;
		endfunction

		function bit fetch_ready();
			int r;
			int c;
			int idx;
			idx = next_source(r, c);
			return loaded[idx];
		endfunction

		function void note_item(logic op, logic [PIXEL_BITS-1:0] pix);
			int total;
			int src;
			int r;
			int c;
			int ow;
			int oh;
			rotated_pixel_t res;
			total = clamp_dim(width) * clamp_dim(height);
			if (op == OP_LOAD) begin
				if (load_pos >= total)
					load_pos = 0;
				frame_pixels[load_pos] = pix;
				loaded[load_pos] = 1'b1;
				load_pos++;
				if (load_pos >= total)
					load_pos = 0;
			end else begin
				src = next_source(r, c);
				out_size(ow, oh);
				res.pixel = frame_pixels[src];
				res.frame_end = (r == oh - 1) && (c == ow - 1);
				pending_pixels.push_back(res);
				if (c + 1 < ow) begin
					out_row = r;
					out_col = c + 1;
				end else begin
					out_col = 0;
					out_row = (r + 1 < oh) ? r + 1 : 0;
				end
			end
		endfunction

		function void check_pixel(logic [PIXEL_BITS-1:0] pix, logic fe);
			rotated_pixel_t exp_px;
			if (pending_pixels.size() == 0) begin
				$error("unexpected output item: pixel_out %h frame_end %b", pix, fe);
				errors++;
				return;
			end
			exp_px = pending_pixels.pop_front();
			if (pix !== exp_px.pixel) begin
				$error("pixel_out mismatch: expected %h, got %h", exp_px.pixel, pix);
				errors++;
			end
			if (fe !== exp_px.frame_end) begin
				$error("frame_end mismatch: expected %b, got %b", exp_px.frame_end, fe);
				errors++;
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    operation = OP_LOAD;
	logic [PIXEL_BITS-1:0]   pixel_in = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [PIXEL_BITS-1:0]   pixel_out;
	logic                    frame_end;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [DIM_BITS-1:0]     cfg_data = '0;

	rotation_scoreboard board;
	int burst_left = 0;
	int random_items = 0;
	int stall_left = 0;
	int stall_style = 0;
	int idle_cycles = 0;

	frame_rotator_quarter_turns_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out),
		.frame_end (frame_end),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [PIXEL_BITS-1:0] rand_pixel();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [DIM_BITS-1:0] pick_dim();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return DIM_BITS'(MAX_DIM);
			2: return DIM_BITS'($urandom_range(MAX_DIM + 1, 2 ** DIM_BITS - 1));
			default: return DIM_BITS'($urandom_range(1, 8));
		endcase
	endfunction

	// sender works in bursts; a gap drops valid only after the previous item went in
	task automatic send_item(input logic op, input logic [PIXEL_BITS-1:0] pix);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		burst_left--;
		operation <= op;
		pixel_in <= pix;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		board.note_item(op, pix);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// sel bit i writes register i; valid stays high across back-to-back writes
	task automatic write_config(input logic [2:0] sel, input logic [DIM_BITS-1:0] mode_data,
			input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
		logic [DIM_BITS-1:0]     values [3];
		logic [CFG_IDX_BITS-1:0] indexes [3];
		values = '{mode_data, w, h};
		indexes = '{REG_ROTATION_MODE, REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT};
		for (int i = 0; i < 3; i++) begin
			if (sel[i]) begin
				cfg_index <= indexes[i];
				cfg_data <= values[i];
				cfg_valid <= 1'b1;
				do @(posedge clk); while (!cfg_ready);
				board.write_reg(indexes[i], values[i]);
			end
		end
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_style = $urandom_range(0, 3);
			stall_left = $urandom_range(8, 80);
		end
		stall_left--;
		case (stall_style)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (stall_left % 4 < 2);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_pixel(pixel_out, frame_end);
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[frame_rotator_quarter_turns_core] ERROR");
		$finish;
	end

	initial begin
		int total;
		int n;
		int fetch_rounds;
		logic [DIM_BITS-1:0] w;
		logic [DIM_BITS-1:0] h;
		logic dims;
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3 wide, 2 tall source with extreme pixels, read back in each mode
		write_config(3'b111, DIM_BITS'(MODE_ROT90), 9'd3, 9'd2);
		send_item(OP_LOAD, 32'h0000_0000);
		send_item(OP_LOAD, 32'hffff_ffff);
		send_item(OP_LOAD, 32'h5555_5555);
		send_item(OP_LOAD, 32'haaaa_aaaa);
		send_item(OP_LOAD, rand_pixel());
		send_item(OP_LOAD, rand_pixel());
		repeat (6) send_item(OP_FETCH, rand_pixel());
		settle();
		write_config(3'b001, DIM_BITS'(MODE_ROT180), '0, '0);
		repeat (6) send_item(OP_FETCH, rand_pixel());
		settle();
		write_config(3'b001, DIM_BITS'(MODE_ROT270_ALT), '0, '0);
		repeat (6) send_item(OP_FETCH, rand_pixel());
		settle();
		// zero width is taken as one
		write_config(3'b111, DIM_BITS'(MODE_ROT270), '0, 9'd1);
		send_item(OP_LOAD, rand_pixel());
		send_item(OP_FETCH, rand_pixel());
		settle();

		while (random_items < RANDOM_ITEMS) begin
			w = pick_dim();
			h = pick_dim();
			// keep large frames to a single row or column
			if (board.clamp_dim(w) > 8)
				h = DIM_BITS'($urandom_range(0, 1));
			else if (board.clamp_dim(h) > 8)
				w = DIM_BITS'($urandom_range(0, 1));
			dims = ($urandom_range(0, 3) != 0);
			write_config({dims, dims, 1'($urandom_range(0, 1))}, DIM_BITS'($urandom()), w, h);
			total = board.clamp_dim(board.width) * board.clamp_dim(board.height);
			if (total <= 64 && $urandom_range(0, 3) != 0) begin
				// whole frame in, then one or two rotated frames out
				fetch_rounds = $urandom_range(1, 2);
				repeat (total) send_item(OP_LOAD, rand_pixel());
				repeat (total * fetch_rounds) send_item(OP_FETCH, rand_pixel());
				random_items += total * (1 + fetch_rounds);
			end else begin
				n = $urandom_range(4, 48);
				repeat (n) begin
					if ($urandom_range(0, 1) == 1 && board.fetch_ready())
						send_item(OP_FETCH, rand_pixel());
					else
						send_item(OP_LOAD, rand_pixel());
				end
				random_items += n;
			end
			settle();
		end

		if (board.errors == 0)
			$display("[frame_rotator_quarter_turns_core] OK");
		else
			$display("[frame_rotator_quarter_turns_core] ERROR");
		$finish;
	end
endmodule

FILE: files.f
rtl/core/frot_pkg.sv
rtl/core/frot_front.sv
rtl/core/frot_queue.sv
rtl/core/frot_back.sv
rtl/core/frame_rotator_quarter_turns_core.sv
tb/tb_frame_rotator_quarter_turns_core.sv
